/* design/vfd_pkg.sv */
// ----------------------------------------------------------------------------
// vfd_pkg - shared definitions for the variable fractional delay line
// Sizes, register codes, interpolation mode codes and the tap word that
// travels from the delay store to the interpolator.
// ----------------------------------------------------------------------------
package vfd_pkg;

   // delay store size (a power of two: read positions wrap by truncation)
   localparam int unsigned BUFFER_DEPTH  = 4096;
   localparam int unsigned FRACTION_BITS = 32;
   localparam int unsigned ADDR_W        = $clog2(BUFFER_DEPTH);
   localparam int unsigned FILL_W        = ADDR_W + 1;

   // sample and accumulator widths
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned ACC_W    = 48;
   localparam int unsigned POS_W    = ADDR_W + FRACTION_BITS;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = ACC_W;
   localparam int unsigned MODE_W      = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INTERP_MODE   = 2'd0,
      CSR_INIT_DELAY    = 2'd1,
      CSR_INIT_VELOCITY = 2'd2,
      CSR_INIT_ACCEL    = 2'd3
   } csr_index_type;

   // interpolation modes; the remaining code also interpolates
   localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd2;

   // taps and fraction handed to the interpolator
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] tap_lo;
      logic signed [SAMPLE_W-1:0] tap_hi;
      logic [FRACTION_BITS-1:0]   frac;
   } tap_word_type;

endpackage

/* design/vfd_interp.sv */
// ----------------------------------------------------------------------------
// vfd_interp - linear interpolator and output register
// Computes tap_lo*(1-f) + tap_hi*f as tap_lo + (tap_hi-tap_lo)*f, truncated
// toward zero, over a multiply stage and an add stage.
// ----------------------------------------------------------------------------
module vfd_interp
   import vfd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  tap_word_type               tap_word,
   output logic                       stage_ready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [SAMPLE_W-1:0]        rsp_tdata      // out_sample
);

   localparam int unsigned DIFF_W = SAMPLE_W + 1;
   localparam int unsigned PROD_W = DIFF_W + FRACTION_BITS + 1;
   localparam int unsigned SUM_W  = PROD_W;

   logic                     out_en;
   logic                     mul_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SAMPLE_W-1:0] base_ff;
   logic                     rsp_valid_ff;
   logic [SAMPLE_W-1:0]      rsp_data_ff;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  base_ext;
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]         biased;

   // stall chain
   assign out_en      = !rsp_valid_ff || rsp_tready;
   assign stage_ready = !mul_valid_ff || out_en;

   // multiply stage: difference of taps times fraction
   always_comb begin
      diff    = {tap_word.tap_hi[SAMPLE_W-1], tap_word.tap_hi}
              - {tap_word.tap_lo[SAMPLE_W-1], tap_word.tap_lo};
      prod_in = PROD_W'(diff * $signed({1'b0, tap_word.frac}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         mul_valid_ff <= tap_word.valid;
      end
      if (stage_ready) begin
         prod_ff <= prod_in;
         base_ff <= tap_word.tap_lo;
      end
   end

   // add stage: scaled base plus product, then truncate toward zero
   always_comb begin
      base_ext = {{(SUM_W-SAMPLE_W-FRACTION_BITS){base_ff[SAMPLE_W-1]}},
                  base_ff, {FRACTION_BITS{1'b0}}};
      sum      = base_ext + prod_ff;
      biased   = sum + {{(SUM_W-FRACTION_BITS){1'b0}}, {FRACTION_BITS{sum[SUM_W-1]}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= mul_valid_ff;
      end
      if (out_en) begin
         rsp_data_ff <= biased[FRACTION_BITS +: SAMPLE_W];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/variable_fractional_delay_line.sv */
// ----------------------------------------------------------------------------
// variable_fractional_delay_line - time-varying fractional delay
// Circular delay store with hold, nearest and linear interpolated reads.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock unless the output stalls, and
// returns one word per sample from its read, multiply and output stages. Each
// accepted sample is written into a 4096-entry delay RAM while both read
// taps for the same sample are fetched from its two read ports in that same
// cycle, so the RAM's one write and two reads per cycle set the rate of one
// sample per clock; a tap that hits the entry being written is forwarded.
// Entries never written since reset read as zero through a fill count, so
// there is no clearing pass and samples are taken right out of reset. The
// delay advances by the velocity and the velocity by the acceleration after
// each sample; a word with req_tuser set restarts the run at write index
// zero with the programmed delay and velocity. Registers are to be written by
// the user only while no samples are in flight; the block does not check it.
// ----------------------------------------------------------------------------
module variable_fractional_delay_line
   import vfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // sample input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_W-1:0]    req_tdata,     // in_sample
   input  logic                   req_tuser,     // first_sample
   // delayed output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]    rsp_tdata      // out_sample
);

   // configuration registers
   logic [MODE_W-1:0] mode_ff;
   logic [ACC_W-1:0]  init_delay_ff;
   logic [ACC_W-1:0]  init_velocity_ff;
   logic [ACC_W-1:0]  accel_ff;

   // run state
   logic [ADDR_W-1:0] widx_ff, widx_in;
   logic [ACC_W-1:0]  delay_ff, delay_in;
   logic [ACC_W-1:0]  velocity_ff, velocity_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // delay RAM
   logic [SAMPLE_W-1:0] delay_store_mem [BUFFER_DEPTH];

   // read stage
   logic                     rd_valid_ff;
   logic [SAMPLE_W-1:0]      rd_a_ff, rd_b_ff;
   logic [SAMPLE_W-1:0]      sample_ff;
   logic                     fwd_a_ff, fwd_b_ff;
   logic                     blank_a_ff, blank_b_ff;
   logic [FRACTION_BITS-1:0] frac_ff;

   // address stage
   logic                     accept;
   logic                     rd_en;
   logic                     stage_ready;
   logic [ADDR_W-1:0]        widx_cur;
   logic [ACC_W-1:0]         delay_cur;
   logic [ACC_W-1:0]         velocity_cur;
   logic [POS_W-1:0]         pos;
   logic [ADDR_W-1:0]        lo_addr, lo_inc, a_addr, b_addr;
   logic [FRACTION_BITS-1:0] frac, frac_eff;
   tap_word_type             tap_word;

   assign rd_en      = !rd_valid_ff || stage_ready;
   assign req_tready = rd_en;
   assign accept     = req_tvalid && rd_en;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_LINEAR;
         init_delay_ff    <= '0;
         init_velocity_ff <= '0;
         accel_ff         <= '0;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_INTERP_MODE:   mode_ff          <= csr_wdata[MODE_W-1:0];
            CSR_INIT_DELAY:    init_delay_ff    <= csr_wdata;
            CSR_INIT_VELOCITY: init_velocity_ff <= csr_wdata;
            CSR_INIT_ACCEL:    accel_ff         <= csr_wdata;
         endcase
      end
   end

   // read position: write index minus delay, wrapped over the store
   always_comb begin
      widx_cur     = req_tuser ? '0 : widx_ff;
      delay_cur    = req_tuser ? init_delay_ff : delay_ff;
      velocity_cur = req_tuser ? init_velocity_ff : velocity_ff;

      pos     = {widx_cur, {FRACTION_BITS{1'b0}}} - delay_cur[POS_W-1:0];
      lo_addr = pos[POS_W-1 -: ADDR_W];
      frac    = pos[FRACTION_BITS-1:0];
      lo_inc  = lo_addr + 1'b1;

      // first tap: floor, or nearest with round half up
      a_addr = lo_addr;
      if (mode_ff == MODE_NEAREST && frac[FRACTION_BITS-1]) begin
         a_addr = lo_inc;
      end
      // second tap: ceiling, same as floor on a whole position
      b_addr = (frac != '0) ? lo_inc : lo_addr;

      frac_eff = (mode_ff == MODE_HOLD || mode_ff == MODE_NEAREST) ? '0 : frac;
   end

   // run state update
   always_comb begin
      widx_in     = widx_ff;
      delay_in    = delay_ff;
      velocity_in = velocity_ff;
      fill_in     = fill_ff;
      if (accept) begin
         widx_in     = widx_cur + 1'b1;
         delay_in    = delay_cur + velocity_cur;
         velocity_in = velocity_cur + accel_ff;
         // written entries always form a prefix of the store
         if ({1'b0, widx_cur} >= fill_ff) begin
            fill_in = {1'b0, widx_cur} + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff     <= '0;
         delay_ff    <= '0;
         velocity_ff <= '0;
         fill_ff     <= '0;
      end else begin
         widx_ff     <= widx_in;
         delay_ff    <= delay_in;
         velocity_ff <= velocity_in;
         fill_ff     <= fill_in;
      end
   end

   // delay RAM: one write, two registered reads
   always_ff @(posedge clock) begin
      if (accept) begin
         delay_store_mem[widx_cur] <= req_tdata;
      end
      if (rd_en) begin
         rd_a_ff <= delay_store_mem[a_addr];
         rd_b_ff <= delay_store_mem[b_addr];
      end
   end

   // read stage side info: forwarding and never-written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= accept;
      end
      if (rd_en) begin
         sample_ff  <= req_tdata;
         fwd_a_ff   <= (a_addr == widx_cur);
         fwd_b_ff   <= (b_addr == widx_cur);
         blank_a_ff <= ({1'b0, a_addr} >= fill_ff);
         blank_b_ff <= ({1'b0, b_addr} >= fill_ff);
         frac_ff    <= frac_eff;
      end
   end

   // tap selection
   always_comb begin
      tap_word.valid  = rd_valid_ff;
      tap_word.tap_lo = fwd_a_ff ? sample_ff : (blank_a_ff ? '0 : rd_a_ff);
      tap_word.tap_hi = fwd_b_ff ? sample_ff : (blank_b_ff ? '0 : rd_b_ff);
      tap_word.frac   = frac_ff;
   end

   vfd_interp u_interp (
      .clock       (clock),
      .reset       (reset),
      .tap_word    (tap_word),
      .stage_ready (stage_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* design/vfd_checker.sv */
// ----------------------------------------------------------------------------
// vfd_checker - port-level checks for the delay line
// Output hold under stall, reset behavior and pipeline latency.
// ----------------------------------------------------------------------------
module vfd_checker
   import vfd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [SAMPLE_W-1:0]    rsp_tdata
);

   // stalled output word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("output word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("output word changed while stalled");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   // with the output draining, an accepted sample reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("sample lost in the pipeline");

endmodule

bind variable_fractional_delay_line vfd_checker u_vfd_checker (.*);

/* sim/tb_variable_fractional_delay_line.sv */
// ----------------------------------------------------------------------------
// tb_variable_fractional_delay_line - self-checking bench for the delay line
// Drives sample words with random gaps and output stalls, and predicts each
// delayed word from a local model of the delay store, accumulators and
// interpolator. A short directed table covers modes, wrap cases and
// accumulator overflow. Random runs with varied register settings follow.
// ----------------------------------------------------------------------------
module tb_variable_fractional_delay_line;

   timeunit 1ns;
   timeprecision 1ps;

   import vfd_pkg::*;

   // run limits
   localparam int unsigned RANDOM_WORDS  = 530;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   // interp_mode code 3 has no name in the package; it interpolates too
   localparam logic [MODE_W-1:0] MODE_LINEAR_ALT = 2'd3;

   // fixed-point constants, 32 fraction bits
   localparam logic [ACC_W-1:0] DELAY_ONE  = 48'h0001_0000_0000;
   localparam logic [ACC_W-1:0] DELAY_HALF = 48'h0000_8000_0000;
   localparam logic [ACC_W-1:0] ACC_MIN    = 48'h8000_0000_0000;
   localparam logic [ACC_W-1:0] ACC_MAX    = 48'h7FFF_FFFF_FFFF;
   localparam longint           FRAC_ONE   = 64'sd1 << FRACTION_BITS;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;

   variable_fractional_delay_line u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // in_sample
      .req_tuser  (req_tuser),     // first_sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)      // out_sample
   );

   always #5ns clock = ~clock;

   // ------------------------------------------------------------------------
   // local copy of the delay line state and registers
   // ------------------------------------------------------------------------
   logic [MODE_W-1:0]          cfg_mode     = MODE_LINEAR;
   logic [ACC_W-1:0]           cfg_delay    = '0;
   logic [ACC_W-1:0]           cfg_velocity = '0;
   logic [ACC_W-1:0]           cfg_accel    = '0;
   logic signed [SAMPLE_W-1:0] tap_mem [BUFFER_DEPTH];
   logic [ADDR_W-1:0]          wr_ptr       = '0;
   logic [ACC_W-1:0]           delay_now    = '0;
   logic [ACC_W-1:0]           velocity_now = '0;

   logic [SAMPLE_W-1:0] out_expected_q [$];
   int unsigned         err_count   = 0;
   int unsigned         cycle_count = 0;
   int unsigned         rsp_gap     = 0;
   bit                  steady      = 1'b0;   // no gaps on either side

   initial begin
      foreach (tap_mem[i]) tap_mem[i] = '0;
   end

   // delayed word for one input word; advances the local state
   function automatic logic [SAMPLE_W-1:0] delay_line_step(logic [SAMPLE_W-1:0] smp,
                                                           logic first);
      longint      pos_full;
      logic [43:0] pos;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [FRACTION_BITS-1:0] frac;
      longint      fr;
      longint      a;
      longint      b;
      longint      res;
      if (first) begin
         wr_ptr       = '0;
         delay_now    = cfg_delay;
         velocity_now = cfg_velocity;
      end
      tap_mem[wr_ptr] = smp;
      // read position wraps modulo the depth: keep the low address+fraction bits
      pos_full = longint'({wr_ptr, 32'd0}) - longint'($signed(delay_now));
      pos  = pos_full[43:0];
      lo   = pos[43:32];
      frac = pos[31:0];
      case (cfg_mode)
         MODE_HOLD: begin
            res = longint'(tap_mem[lo]);
         end
         MODE_NEAREST: begin
            hi  = frac[31] ? lo + 1'b1 : lo;
            res = longint'(tap_mem[hi]);
         end
         default: begin
            hi  = (frac != 0) ? lo + 1'b1 : lo;
            fr  = longint'({32'd0, frac});
            a   = longint'(tap_mem[lo]);
            b   = longint'(tap_mem[hi]);
            res = (a * (FRAC_ONE - fr) + b * fr) / FRAC_ONE;
         end
      endcase
      delay_now    = delay_now + velocity_now;
      velocity_now = velocity_now + cfg_accel;
      wr_ptr       = wr_ptr + 1'b1;
      return res[SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      err_count++;
   endtask

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         CSR_INTERP_MODE:   cfg_mode     = value[MODE_W-1:0];
         CSR_INIT_DELAY:    cfg_delay    = value;
         CSR_INIT_VELOCITY: cfg_velocity = value;
         CSR_INIT_ACCEL:    cfg_accel    = value;
      endcase
   endtask

   // send one word; a typed expectation overrides the predicted one
   task automatic send_word(logic [SAMPLE_W-1:0] smp, logic first,
                            bit typed, logic [SAMPLE_W-1:0] want);
      int unsigned        gap;
      logic [SAMPLE_W-1:0] predicted;
      gap = steady ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      predicted = delay_line_step(smp, first);
      out_expected_q.push_back(typed ? want : predicted);
   endtask

   // stop sending, let every expected word arrive, then let the pipe settle
   task automatic drain_and_settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (out_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // output side: random stalls, check at the rising edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_gap != 0) begin
         rsp_tready <= 1'b0;
         rsp_gap = rsp_gap - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (out_expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word out_sample=%h", rsp_tdata));
         end else begin
            want = out_expected_q.pop_front();
            if (rsp_tdata !== want)
               report_mismatch($sformatf("out_sample got %h want %h", rsp_tdata, want));
         end
         rsp_gap = steady ? 0 : $urandom_range(0, 3);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------------
   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      csr_index_type       index;
      logic [ACC_W-1:0]    value;
      logic [SAMPLE_W-1:0] sample;
      logic                first;
      logic                typed;
      logic [SAMPLE_W-1:0] want;
   } dir_row_type;

   localparam int unsigned DIR_ROWS = 41;

   dir_row_type dir_tab [DIR_ROWS] = '{
      // out of reset: linear, zero delay returns the current word
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h8000, 1'b0, 1'b1, 16'h8000},
      '{ROW_CSR,  CSR_INTERP_MODE,   48'(MODE_HOLD),   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_DELAY,    DELAY_ONE,        16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_VELOCITY, 48'd0,            16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_ACCEL,    48'd0,            16'h0000, 1'b0, 1'b0, 16'h0000},
      // delay register not live until a run starts
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h1234, 1'b0, 1'b1, 16'h1234},
      // run start, delay 1: read wraps to the never-written top entry
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h1234, 1'b1, 1'b1, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h5555, 1'b0, 1'b1, 16'h1234},
      '{ROW_CSR,  CSR_INTERP_MODE,   48'(MODE_NEAREST),16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_DELAY,    DELAY_HALF,       16'h0000, 1'b0, 1'b0, 16'h0000},
      // nearest rounds half up past the end back to tap 0
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h0100, 1'b1, 1'b1, 16'h0100},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h0200, 1'b0, 1'b1, 16'h0200},
      '{ROW_CSR,  CSR_INTERP_MODE,   48'(MODE_LINEAR), 16'h0000, 1'b0, 1'b0, 16'h0000},
      // half-way linear: ceiling tap wraps; negative sums truncate toward zero
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h0100, 1'b1, 1'b1, 16'h0080},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h0300, 1'b0, 1'b1, 16'h0200},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'hFFFD, 1'b0, 1'b1, 16'h017E},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h8000, 1'b0, 1'b1, 16'hBFFF},
      '{ROW_CSR,  CSR_INTERP_MODE,   48'(MODE_LINEAR_ALT), 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h0010, 1'b1, 1'b1, 16'h0008},
      // negative delay reads ahead of the write pointer
      '{ROW_CSR,  CSR_INTERP_MODE,   48'(MODE_HOLD),   16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_DELAY,    48'hFFFE_0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h7FFF, 1'b1, 1'b1, 16'hFFFD},
      // most negative delay is a multiple of the depth
      '{ROW_CSR,  CSR_INIT_DELAY,    ACC_MIN,          16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h4321, 1'b1, 1'b1, 16'h4321},
      // extreme registers, accumulators wrap
      '{ROW_CSR,  CSR_INTERP_MODE,   48'(MODE_LINEAR), 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_DELAY,    ACC_MAX,          16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_VELOCITY, ACC_MAX,          16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_ACCEL,    ACC_MIN,          16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'hAAAA, 1'b1, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h5555, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h0000, 1'b0, 1'b0, 16'h0000},
      // slowly sweeping delay in nearest mode
      '{ROW_CSR,  CSR_INTERP_MODE,   48'(MODE_NEAREST),16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_DELAY,    48'h0003_0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_VELOCITY, 48'h0000_4000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_CSR,  CSR_INIT_ACCEL,    48'hFFFF_FFF0_0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h1111, 1'b1, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h2222, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h3333, 1'b0, 1'b0, 16'h0000},
      '{ROW_WORD, CSR_INTERP_MODE,   48'd0,            16'h4444, 1'b0, 1'b0, 16'h0000}
   };

   // ------------------------------------------------------------------------
   // random register values
   // ------------------------------------------------------------------------
   function automatic logic [ACC_W-1:0] wide_random();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[ACC_W-1:0];
   endfunction

   function automatic logic [ACC_W-1:0] pick_delay();
      int          whole;
      logic [31:0] whole_bits;
      case ($urandom_range(0, 9))
         0: return ACC_MIN;
         1: return ACC_MAX;
         2: return wide_random();
         default: begin
            // mostly within the store, a few taps either side of it
            whole      = int'($urandom_range(0, BUFFER_DEPTH + 12)) - 8;
            whole_bits = whole;
            return {whole_bits[15:0], 32'($urandom)};
         end
      endcase
   endfunction

   function automatic logic [ACC_W-1:0] pick_rate(int unsigned span_bits);
      longint step;
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2:    return ACC_MIN;
         3:    return ACC_MAX;
         4:    return wide_random();
         default: begin
            step = longint'($urandom_range(0, (32'd1 << (span_bits + 1)) - 1))
                   - (64'sd1 << span_bits);
            return step[ACC_W-1:0];
         end
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      int unsigned sent;
      int unsigned run_len;
      logic        first;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            drain_and_settle();
            csr_write(dir_tab[i].index, dir_tab[i].value);
         end else begin
            send_word(dir_tab[i].sample, dir_tab[i].first,
                      dir_tab[i].typed, dir_tab[i].want);
         end
      end

      // random runs, each after the pipe has emptied
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         drain_and_settle();
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            csr_write(CSR_INTERP_MODE, 48'($urandom_range(0, 3)));
            csr_write(CSR_INIT_DELAY, pick_delay());
            csr_write(CSR_INIT_VELOCITY, pick_rate(28));
            csr_write(CSR_INIT_ACCEL, pick_rate(14));
         end
         run_len = $urandom_range(8, 40);
         for (int unsigned k = 0; k < run_len; k++) begin
            if (k == 0)
               first = ($urandom_range(0, 5) != 0);
            else
               first = ($urandom_range(0, 31) == 0);
            send_word(pick_sample(), first, 1'b0, '0);
            sent++;
         end
      end

      drain_and_settle();
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/vfd_pkg.sv
design/vfd_interp.sv
design/variable_fractional_delay_line.sv
design/vfd_checker.sv
sim/tb_variable_fractional_delay_line.sv
